[rtl/core/bmig_pkg.sv]
package bmig_pkg;

   localparam int ACTION_W    = 2;
   localparam int ADDRESS_W   = 16;
   localparam int DATA_W      = 8;
   localparam int TARGET_W    = 3;
   localparam int PHYS_W      = 19;
   localparam int DEVREG_W    = 3;
   localparam int BANK_W      = 4;

   // Bus access kinds.
   localparam logic [ACTION_W-1:0] ACT_MEM_READ  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_MEM_WRITE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_IO_READ   = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_IO_WRITE  = 2'd3;

   // Decoded targets.
   localparam logic [TARGET_W-1:0] TGT_ROM      = 3'd0;
   localparam logic [TARGET_W-1:0] TGT_RAM      = 3'd1;
   localparam logic [TARGET_W-1:0] TGT_SERIAL   = 3'd2;
   localparam logic [TARGET_W-1:0] TGT_DISK     = 3'd3;
   localparam logic [TARGET_W-1:0] TGT_INTERNAL = 3'd4;
   localparam logic [TARGET_W-1:0] TGT_IGNORED  = 3'd5;
   localparam logic [TARGET_W-1:0] TGT_UNMAPPED = 3'd6;

   // Opcode bytes watched by the snoop.
   localparam logic [DATA_W-1:0] OP_ED = 8'hED;
   localparam logic [DATA_W-1:0] OP_4D = 8'h4D;
   localparam logic [DATA_W-1:0] OP_DD = 8'hDD;
   localparam logic [DATA_W-1:0] OP_FD = 8'hFD;
   localparam logic [DATA_W-1:0] OP_CB = 8'hCB;

   // I/O ports of the internal registers.
   localparam logic [7:0] PORT_BANK       = 8'h30;
   localparam logic [7:0] PORT_ROM_OFF    = 8'h38;
   localparam logic [7:0] PORT_SERIAL_MAX = 8'h03;
   localparam logic [7:0] PORT_DISK_MIN   = 8'h10;
   localparam logic [7:0] PORT_DISK_MAX   = 8'h17;

   typedef enum logic [1:0] {
      SNOOP_IDLE     = 2'd0,
      SNOOP_AFTER_ED = 2'd1,
      SNOOP_PREFIX   = 2'd2
   } snoop_type;

   typedef struct packed {
      logic [ACTION_W-1:0]  action;
      logic [ADDRESS_W-1:0] address;
      logic [DATA_W-1:0]    bus_data;
      logic                 opcode_fetch;
   } req_type;

   typedef struct packed {
      logic [TARGET_W-1:0] target;
      logic [PHYS_W-1:0]   phys_address;
      logic [DEVREG_W-1:0] device_register;
      logic                write_strobe;
      logic                reti_seen;
   } rsp_type;

   typedef struct packed {
      logic [BANK_W-1:0] ram_bank;
      logic              rom_enabled;
      snoop_type         snoop;
   } glue_state_type;

endpackage

[rtl/core/bmig_if.sv]
interface bmig_req_if import bmig_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [ACTION_W-1:0]  action;
   logic [ADDRESS_W-1:0] address;
   logic [DATA_W-1:0]    bus_data;
   logic                 opcode_fetch;

   modport source (output valid, action, address, bus_data, opcode_fetch, input ready);
   modport sink   (input valid, action, address, bus_data, opcode_fetch, output ready);
endinterface

interface bmig_rsp_if import bmig_pkg::*;;
   logic                valid;
   logic                ready;
   logic [TARGET_W-1:0] target;
   logic [PHYS_W-1:0]   phys_address;
   logic [DEVREG_W-1:0] device_register;
   logic                write_strobe;
   logic                reti_seen;

   modport source (output valid, target, phys_address, device_register, write_strobe,
                   reti_seen, input ready);
   modport sink   (input valid, target, phys_address, device_register, write_strobe,
                   reti_seen, output ready);
endinterface

[rtl/core/bmig_decode.sv]
module bmig_decode import bmig_pkg::*; (
   input  req_type        item,
   input  glue_state_type cur,
   output rsp_type        result,
   output glue_state_type nxt
);

   logic [7:0]        port;
   logic              rom_hit;
   logic [PHYS_W-1:0] ram_phys;
   logic              is_serial;
   logic              is_disk;
   logic              is_prefix;

   always_comb begin
      port      = item.address[7:0];
      rom_hit   = (item.address[15:14] == 2'b00) && cur.rom_enabled;
      is_serial = (port <= PORT_SERIAL_MAX);
      is_disk   = (port >= PORT_DISK_MIN) && (port <= PORT_DISK_MAX);
      is_prefix = (item.bus_data == OP_DD) || (item.bus_data == OP_FD)
                  || (item.bus_data == OP_CB);

      // The low half of the CPU space is a window into one 32K bank.
      if (item.address[15]) begin
         ram_phys = {{(PHYS_W-ADDRESS_W){1'b0}}, item.address};
      end else begin
         ram_phys = {cur.ram_bank, item.address[14:0]};
      end

      result.target          = TGT_UNMAPPED;
      result.phys_address    = '0;
      result.device_register = '0;
      result.write_strobe    = 1'b0;
      result.reti_seen       = 1'b0;
      nxt                    = cur;

      unique case (item.action)
         ACT_MEM_READ: begin
            if (rom_hit) begin
               result.target       = TGT_ROM;
               result.phys_address = {{(PHYS_W-ADDRESS_W){1'b0}}, item.address};
            end else begin
               result.target       = TGT_RAM;
               result.phys_address = ram_phys;
            end
            priority if (item.opcode_fetch && is_prefix) begin
               nxt.snoop = SNOOP_PREFIX;
            end else if (item.opcode_fetch && item.bus_data == OP_ED
                         && cur.snoop == SNOOP_IDLE) begin
               nxt.snoop = SNOOP_AFTER_ED;
            end else begin
               result.reti_seen = (item.bus_data == OP_4D) && (cur.snoop == SNOOP_AFTER_ED);
               nxt.snoop        = SNOOP_IDLE;
            end
         end
         ACT_MEM_WRITE: begin
            if (rom_hit) begin
               result.target = TGT_IGNORED;
            end else begin
               result.target       = TGT_RAM;
               result.phys_address = ram_phys;
               result.write_strobe = 1'b1;
            end
         end
         ACT_IO_READ: begin
            priority if (is_serial) begin
               result.target          = TGT_SERIAL;
               result.device_register = {1'b0, port[1:0]};
            end else if (is_disk) begin
               result.target          = TGT_DISK;
               result.device_register = port[2:0];
            end else begin
               result.target = TGT_UNMAPPED;
            end
         end
         ACT_IO_WRITE: begin
            priority if (is_serial) begin
               result.target          = TGT_SERIAL;
               result.device_register = {1'b0, port[1:0]};
               result.write_strobe    = 1'b1;
            end else if (is_disk) begin
               result.target          = TGT_DISK;
               result.device_register = port[2:0];
               result.write_strobe    = 1'b1;
            end else if (port == PORT_BANK) begin
               result.target       = TGT_INTERNAL;
               result.write_strobe = 1'b1;
               nxt.ram_bank        = item.bus_data[BANK_W-1:0];
            end else if (port == PORT_ROM_OFF) begin
               result.target       = TGT_INTERNAL;
               result.write_strobe = 1'b1;
               nxt.rom_enabled     = 1'b0;
            end else begin
               result.target = TGT_IGNORED;
            end
         end
         default: begin
            result.target = TGT_UNMAPPED;
         end
      endcase
   end

endmodule

[rtl/core/banked_memory_io_glue_reti_snoop_top.sv]
// Channel  Direction  Contents
// req_bus  in         action, address, bus_data, opcode_fetch (one bus request)
// rsp_bus  out        target, phys_address, device_register, write_strobe, reti_seen
//
// A request is registered in the input stage when it is accepted. It waits there while the
// decoder works on it, and the result register takes the decode once the result stage
// is free. A request can go in every cycle unless the result side stalls.
// Reset (synchronous, active high) empties both stages, clears the RAM bank, enables
// the ROM and sets the opcode snoop idle. req_bus.ready falls only while both stages
// hold a request and rsp_bus.ready is low.
module banked_memory_io_glue_reti_snoop_top import bmig_pkg::*; (
   input logic   clock,
   input logic   reset,
   bmig_req_if.sink   req_bus,
   bmig_rsp_if.source rsp_bus
);

   // Input stage.
   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff,  in_item_in;

   // Result stage.
   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff,  out_item_in;

   // Glue registers: bank, ROM latch and snoop. They advance only when a
   // request moves from the input stage into the result stage, so each
   // request sees exactly the state left by the one before it.
   glue_state_type state_ff, state_in;
   glue_state_type state_next;
   rsp_type        decoded;

   logic advance;
   logic out_free;

   bmig_decode u_decode (
      .item   (in_item_ff),
      .cur    (state_ff),
      .result (decoded),
      .nxt    (state_next)
   );

   always_comb begin
      out_free = !out_valid_ff || rsp_bus.ready;
      advance  = in_valid_ff && out_free;

      req_bus.ready = !in_valid_ff || advance;

      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_bus.valid && req_bus.ready) begin
         in_valid_in             = 1'b1;
         in_item_in.action       = req_bus.action;
         in_item_in.address      = req_bus.address;
         in_item_in.bus_data     = req_bus.bus_data;
         in_item_in.opcode_fetch = req_bus.opcode_fetch;
      end

      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      state_in     = state_ff;
      if (out_valid_ff && rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_item_in  = decoded;
         state_in     = state_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         out_valid_ff         <= 1'b0;
         state_ff.ram_bank    <= '0;
         state_ff.rom_enabled <= 1'b1;
         state_ff.snoop       <= SNOOP_IDLE;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.target          = out_item_ff.target;
   assign rsp_bus.phys_address    = out_item_ff.phys_address;
   assign rsp_bus.device_register = out_item_ff.device_register;
   assign rsp_bus.write_strobe    = out_item_ff.write_strobe;
   assign rsp_bus.reti_seen       = out_item_ff.reti_seen;

endmodule

[sim/tb_banked_memory_io_glue_reti_snoop_top.sv]
`timescale 1ns / 1ps

module tb_banked_memory_io_glue_reti_snoop_top;
   import bmig_pkg::*;

   // Address boundaries of the board's memory map.
   localparam logic [ADDRESS_W-1:0] ROM_TOP    = 16'h4000;
   localparam logic [ADDRESS_W-1:0] BANKED_TOP = 16'h8000;

   // Random traffic is split in two halves: the first runs with the ROM still
   // mapped, the second after the ROM disable port has been written.
   localparam int TRAFFIC_HALF  = 325;
   // The last requests of the run go through without any idling.
   localparam int QUIET_TAIL    = 100;
   // The long result-side stall starts once this many requests are in.
   localparam int HOLD_AFTER    = 150;
   localparam int HOLD_CYCLES   = 80;
   localparam int DRAIN_CYCLES  = 8;
   localparam int LIMIT_CYCLES  = 100000;

   logic clock;
   logic reset;

   bmig_req_if req_bus ();
   bmig_rsp_if rsp_bus ();

   banked_memory_io_glue_reti_snoop_top DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Requests waiting to be offered, and the decodes still owed by the block.
   req_type pending_reqs[$];
   rsp_type expected_rsps[$];

   int total_reqs;
   int accepted_count;
   int cycle_count;
   int fail_count;

   // Set at a rising edge when the request on the bus was taken there.
   logic req_taken;

   int send_gap;
   int recv_gap;
   int hold_left;
   bit hold_done;

   // Our own copy of the glue state, advanced once per accepted request.
   logic [BANK_W-1:0] bank_now;
   logic              rom_on;
   snoop_type         snoop_now;

   always #6 clock = ~clock;

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------

   // Lower 32K of the CPU space is windowed into the selected bank; the
   // upper 32K always maps straight to the second 32K of RAM, the same RAM as bank 1.
   function automatic logic [PHYS_W-1:0] bank_address(input logic [ADDRESS_W-1:0] addr);
      if (addr >= BANKED_TOP)
         return {3'b000, addr};
      return {bank_now, addr[14:0]};
   endfunction

   // Decodes one bus request against the current glue state and updates
   // that state the way the board would.
   function automatic rsp_type decode_access(input req_type acc);
      rsp_type      r;
      logic [7:0]   port;
      logic         serial_port;
      logic         disk_port;
      r           = '0;
      r.target    = TGT_UNMAPPED;
      port        = acc.address[7:0];
      serial_port = (port <= PORT_SERIAL_MAX);
      disk_port   = (port >= PORT_DISK_MIN) && (port <= PORT_DISK_MAX);
      case (acc.action)
         ACT_MEM_READ: begin
            if (acc.address < ROM_TOP && rom_on) begin
               r.target       = TGT_ROM;
               r.phys_address = {3'b000, acc.address};
            end else begin
               r.target       = TGT_RAM;
               r.phys_address = bank_address(acc.address);
            end
            // A prefix byte parks the snoop so that a following ED is not
            // mistaken for the start of a return-from-interrupt.
            if (acc.opcode_fetch && (acc.bus_data == OP_DD || acc.bus_data == OP_FD ||
                                     acc.bus_data == OP_CB)) begin
               snoop_now = SNOOP_PREFIX;
            end else if (acc.opcode_fetch && acc.bus_data == OP_ED &&
                         snoop_now == SNOOP_IDLE) begin
               snoop_now = SNOOP_AFTER_ED;
            end else begin
               r.reti_seen = (acc.bus_data == OP_4D) && (snoop_now == SNOOP_AFTER_ED);
               snoop_now   = SNOOP_IDLE;
            end
         end
         ACT_MEM_WRITE: begin
            // Writes into the ROM window fall on the floor while ROM is mapped.
            if (acc.address < ROM_TOP && rom_on) begin
               r.target = TGT_IGNORED;
            end else begin
               r.target       = TGT_RAM;
               r.phys_address = bank_address(acc.address);
               r.write_strobe = 1'b1;
            end
         end
         ACT_IO_READ: begin
            if (serial_port) begin
               r.target          = TGT_SERIAL;
               r.device_register = {1'b0, port[1:0]};
            end else if (disk_port) begin
               r.target          = TGT_DISK;
               r.device_register = port[2:0];
            end
         end
         default: begin
            if (serial_port) begin
               r.target          = TGT_SERIAL;
               r.device_register = {1'b0, port[1:0]};
               r.write_strobe    = 1'b1;
            end else if (disk_port) begin
               r.target          = TGT_DISK;
               r.device_register = port[2:0];
               r.write_strobe    = 1'b1;
            end else if (port == PORT_BANK) begin
               r.target       = TGT_INTERNAL;
               r.write_strobe = 1'b1;
               bank_now       = acc.bus_data[BANK_W-1:0];
            end else if (port == PORT_ROM_OFF) begin
               // Only reset brings the ROM back.
               r.target       = TGT_INTERNAL;
               r.write_strobe = 1'b1;
               rom_on         = 1'b0;
            end else begin
               r.target = TGT_IGNORED;
            end
         end
      endcase
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus building
   // ------------------------------------------------------------------

   task automatic add_req(input logic [ACTION_W-1:0] act, input logic [ADDRESS_W-1:0] addr,
                          input logic [DATA_W-1:0] data, input logic m1);
      req_type acc;
      acc.action       = act;
      acc.address      = addr;
      acc.bus_data     = data;
      acc.opcode_fetch = m1;
      pending_reqs.push_back(acc);
   endtask

   function automatic logic [DATA_W-1:0] snoop_byte();
      case ($urandom_range(0, 4))
         0: return OP_ED;
         1: return OP_4D;
         2: return OP_DD;
         3: return OP_FD;
         default: return OP_CB;
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] prefix_byte();
      case ($urandom_range(0, 2))
         0: return OP_DD;
         1: return OP_FD;
         default: return OP_CB;
      endcase
   endfunction

   // I/O address with random upper byte; ports lean toward the decoded ones.
   // The ROM disable port is kept out while the ROM half of the run is built.
   function automatic logic [ADDRESS_W-1:0] io_address(input bit allow_rom_off);
      logic [7:0] port;
      case ($urandom_range(0, 5))
         0: port = 8'($urandom_range(0, 3));
         1: port = 8'($urandom_range(PORT_DISK_MIN, PORT_DISK_MAX));
         2: port = PORT_BANK;
         3: port = PORT_ROM_OFF;
         default: port = 8'($urandom);
      endcase
      if (!allow_rom_off && port == PORT_ROM_OFF)
         port = PORT_BANK;
      return {8'($urandom), port};
   endfunction

   // Mostly well-formed opcode streams (ED 4D pairs, prefixed EDs, reads
   // interleaved with non-snooped accesses) with random bus traffic mixed in.
   task automatic gen_traffic(input int count, input bit allow_rom_off);
      int kind;
      int made;
      made = 0;
      while (made < count) begin
         kind = $urandom_range(0, 99);
         if (kind < 30) begin
            add_req(ACT_MEM_READ, 16'($urandom), OP_ED, $urandom_range(0, 7) != 0);
            made++;
            if ($urandom_range(0, 2) == 0) begin
               add_req(ACT_MEM_WRITE + 2'($urandom_range(0, 2)), 16'($urandom),
                       8'($urandom), 1'($urandom));
               made++;
            end
            add_req(ACT_MEM_READ, 16'($urandom),
                    $urandom_range(0, 4) != 0 ? OP_4D : 8'($urandom), 1'($urandom));
            made++;
         end else if (kind < 40) begin
            add_req(ACT_MEM_READ, 16'($urandom), prefix_byte(), 1'b1);
            add_req(ACT_MEM_READ, 16'($urandom), OP_ED, 1'b1);
            add_req(ACT_MEM_READ, 16'($urandom), OP_4D, 1'($urandom));
            made += 3;
         end else if (kind < 60) begin
            add_req(ACT_MEM_READ, 16'($urandom),
                    $urandom_range(0, 2) == 0 ? snoop_byte() : 8'($urandom), 1'($urandom));
            made++;
         end else if (kind < 72) begin
            add_req(ACT_MEM_WRITE, 16'($urandom), 8'($urandom), 1'($urandom));
            made++;
         end else if (kind < 82) begin
            add_req(ACT_IO_READ, io_address(allow_rom_off), 8'($urandom), 1'($urandom));
            made++;
         end else if (kind < 95) begin
            add_req(ACT_IO_WRITE, io_address(allow_rom_off), 8'($urandom), 1'($urandom));
            made++;
         end else begin
            add_req(ACT_IO_WRITE, {8'($urandom), PORT_BANK}, 8'($urandom), 1'($urandom));
            made++;
         end
      end
   endtask

   // Idling is allowed in two of every three windows of 40 requests and never
   // in the quiet tail of the run.
   function automatic bit idling_allowed();
      return (accepted_count + QUIET_TAIL < total_reqs) && ((accepted_count / 40) % 3 != 0);
   endfunction

   function automatic bit in_hold_window();
      return accepted_count >= HOLD_AFTER && accepted_count < HOLD_AFTER + 20;
   endfunction

   // ------------------------------------------------------------------
   // Request driver: changes the bus at the falling edge only.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      req_type upcoming;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         // The bus is free: either nothing was offered or the last request
         // went in at the previous rising edge.
         if (send_gap > 0) begin
            send_gap      <= send_gap - 1;
            req_bus.valid <= 1'b0;
         end else if (pending_reqs.size() == 0) begin
            req_bus.valid <= 1'b0;
         end else if (idling_allowed() && !in_hold_window() && $urandom_range(0, 3) == 0) begin
            send_gap      <= $urandom_range(0, 8);
            req_bus.valid <= 1'b0;
         end else begin
            upcoming             = pending_reqs.pop_front();
            req_bus.action       <= upcoming.action;
            req_bus.address      <= upcoming.address;
            req_bus.bus_data     <= upcoming.bus_data;
            req_bus.opcode_fetch <= upcoming.opcode_fetch;
            req_bus.valid        <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------
   // Result receiver: random stall bursts, plus one long hold-off that lets
   // both pipeline stages fill so the block has to drop req_bus.ready.
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else if (!hold_done && accepted_count >= HOLD_AFTER) begin
         hold_done     <= 1'b1;
         hold_left     <= HOLD_CYCLES - 1;
         rsp_bus.ready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap      <= recv_gap - 1;
         rsp_bus.ready <= 1'b0;
      end else if (idling_allowed() && $urandom_range(0, 3) == 0) begin
         recv_gap      <= $urandom_range(0, 8);
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   // ------------------------------------------------------------------
   // Monitor: samples both handshakes at the rising edge. A result is
   // always older than any request taken at the same edge, so it is
   // checked before the new request's decode is queued.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      req_type acc;
      cycle_count++;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_bus.valid && req_bus.ready;
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: result with no request outstanding, expected none, actual %0h",
                        $time, {rsp_bus.target, rsp_bus.phys_address, rsp_bus.device_register,
                                rsp_bus.write_strobe, rsp_bus.reti_seen});
               fail_count++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("target", 32'(want.target), 32'(rsp_bus.target));
               check_field("phys_address", 32'(want.phys_address),
                           32'(rsp_bus.phys_address));
               check_field("device_register", 32'(want.device_register),
                           32'(rsp_bus.device_register));
               check_field("write_strobe", 32'(want.write_strobe),
                           32'(rsp_bus.write_strobe));
               check_field("reti_seen", 32'(want.reti_seen), 32'(rsp_bus.reti_seen));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            acc.action       = req_bus.action;
            acc.address      = req_bus.address;
            acc.bus_data     = req_bus.bus_data;
            acc.opcode_fetch = req_bus.opcode_fetch;
            expected_rsps.push_back(decode_access(acc));
            accepted_count++;
         end
      end
   end

   // Watchdog on the cycle count kept by the monitor.
   initial begin
      while (cycle_count < LIMIT_CYCLES)
         @(posedge clock);
      $display("banked_memory_io_glue_reti_snoop_top regression: fail");
      $finish;
   end

   // ------------------------------------------------------------------
   // Main sequence: build every request up front, release reset, then
   // wait for the block to drain.
   // ------------------------------------------------------------------
   initial begin
      clock                = 1'b0;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.action       = ACT_MEM_READ;
      req_bus.address      = '0;
      req_bus.bus_data     = '0;
      req_bus.opcode_fetch = 1'b0;
      rsp_bus.ready        = 1'b0;
      req_taken            = 1'b0;
      accepted_count       = 0;
      cycle_count          = 0;
      fail_count           = 0;
      send_gap             = 0;
      recv_gap             = 0;
      hold_left            = 0;
      hold_done            = 1'b0;
      bank_now             = '0;
      rom_on               = 1'b1;
      snoop_now            = SNOOP_IDLE;

      // Memory map corners with the ROM mapped and bank zero selected.
      add_req(ACT_MEM_READ,  16'h0000, 8'h00, 1'b1);
      add_req(ACT_MEM_READ,  16'h3FFF, 8'hFF, 1'b0);
      add_req(ACT_MEM_READ,  16'h4000, 8'h00, 1'b0);
      add_req(ACT_MEM_READ,  16'hFFFF, 8'hFF, 1'b1);
      add_req(ACT_MEM_WRITE, 16'h0000, 8'hAA, 1'b1);
      add_req(ACT_MEM_WRITE, 16'h7FFF, 8'h55, 1'b0);
      // A clean return-from-interrupt, the second byte not an opcode fetch.
      add_req(ACT_MEM_READ,  16'h0100, OP_ED, 1'b1);
      add_req(ACT_MEM_READ,  16'h0101, OP_4D, 1'b0);
      // A second ED while the first is pending ends the match; the 4D after it is no RETI.
      add_req(ACT_MEM_READ,  16'h0200, OP_ED, 1'b1);
      add_req(ACT_MEM_READ,  16'h0201, OP_ED, 1'b1);
      add_req(ACT_MEM_READ,  16'h0202, OP_4D, 1'b0);
      // An ED right after an index prefix is not the start of a match.
      add_req(ACT_MEM_READ,  16'h0300, OP_DD, 1'b1);
      add_req(ACT_MEM_READ,  16'h0301, OP_ED, 1'b1);
      add_req(ACT_MEM_READ,  16'h0302, OP_4D, 1'b1);
      // Writes and I/O between ED and 4D leave the snoop alone.
      add_req(ACT_MEM_READ,  16'h0400, OP_ED, 1'b1);
      add_req(ACT_MEM_WRITE, 16'h9000, OP_4D, 1'b0);
      add_req(ACT_IO_WRITE,  16'hFF02, 8'h4D, 1'b1);
      add_req(ACT_MEM_READ,  16'h0401, OP_4D, 1'b1);
      // I/O decode: serial, disk, internal ports read back as unmapped.
      add_req(ACT_IO_READ,   16'hFF00, 8'h00, 1'b1);
      add_req(ACT_IO_READ,   16'h0017, 8'hFF, 1'b0);
      add_req(ACT_IO_READ,   16'h1238, 8'h00, 1'b0);
      add_req(ACT_IO_WRITE,  16'h0013, 8'hFF, 1'b0);
      add_req(ACT_IO_WRITE,  16'h00FF, 8'h00, 1'b0);
      // Top bank, then the highest banked address.
      add_req(ACT_IO_WRITE,  16'h0030, 8'hFF, 1'b0);
      add_req(ACT_MEM_WRITE, 16'h7FFF, 8'h00, 1'b0);

      gen_traffic(TRAFFIC_HALF, 1'b0);

      // Unmap the ROM; reads and writes below 16K now reach banked RAM.
      add_req(ACT_IO_WRITE,  16'hA538, 8'($urandom), 1'b0);
      add_req(ACT_MEM_READ,  16'h0000, 8'h00, 1'b1);
      add_req(ACT_MEM_WRITE, 16'h3FFF, 8'hFF, 1'b1);

      gen_traffic(TRAFFIC_HALF, 1'b1);
      total_reqs = pending_reqs.size();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (accepted_count < total_reqs || expected_rsps.size() != 0)
         @(posedge clock);
      // Let a stray extra result show up if the block produces one.
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0)
         $display("banked_memory_io_glue_reti_snoop_top regression: pass");
      else
         $display("banked_memory_io_glue_reti_snoop_top regression: fail");
      $finish;
   end

endmodule
